>>> sv/npcs_pkg.sv
// shared types and constants for the nearest palette color search
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int DEFAULT_PALETTE_DEPTH = 256;
    localparam int COLOR_W               = 8;
    localparam int INDEX_W               = 8;
    localparam int COUNT_W               = 9;
    localparam int SQ_W                  = 2 * COLOR_W;
    localparam int DIST_W                = 18;
    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256 + 1);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic issue;
        logic load_out;
    } t_ctrl;

endpackage

>>> sv/nearest_palette_color_search_top.sv
// nearest palette color search: palette memory, scan sequencer and distance unit
//
// input channel (i_in_valid / o_in_ready) carries one request: op, entry_index and
// an rgb color. a write request stores the color at entry_index and
// gives no result; an index not below PALETTE_DEPTH is dropped. a query request
// scans entries 0 .. palette_count-1 (saturated to PALETTE_DEPTH) and gives one
// result, the index of the closest entry, lowest index on a tie, 0 for an empty
// palette. the config channel (i_cfg_valid / o_cfg_ready) writes palette_count
// and is always ready; write it only while the block is idle.
// a query occupies the block until the scan drains and the result loads: the single
// distance unit takes one entry per cycle behind a registered memory read and a square
// stage. o_in_ready is low during the scan. the result sits in
// an output register (o_out_valid / i_out_ready); while it waits, new requests are
// still taken, and a later query holds in its last state until the register frees up.
// reset clears control state and sets palette_count to 256; palette contents
// are undefined until written, so no clearing pass is needed.
`timescale 1ns / 1ps

module nearest_palette_color_search_top #(
    parameter int PALETTE_DEPTH = npcs_pkg::DEFAULT_PALETTE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [npcs_pkg::COUNT_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [npcs_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]    i_red,
    input  logic [npcs_pkg::COLOR_W-1:0]    i_green,
    input  logic [npcs_pkg::COLOR_W-1:0]    i_blue,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [npcs_pkg::INDEX_W-1:0]    o_nearest_index
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int CLR_W = npcs_pkg::COLOR_W;
    localparam int SQ_W = npcs_pkg::SQ_W;
    localparam int DIST_W = npcs_pkg::DIST_W;

    logic [3*CLR_W-1:0]             r_palette [PALETTE_DEPTH];

    npcs_pkg::t_state               r_state, n_state;
    npcs_pkg::t_ctrl                w_ctrl;

    logic [npcs_pkg::COUNT_W-1:0]   r_palette_count;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_addr;
    logic [CLR_W-1:0]               r_red, r_green, r_blue;

    logic                           r_rd_vld;
    logic [AW-1:0]                  r_rd_idx;
    logic [3*CLR_W-1:0]             r_rd_data;

    logic                           r_sq_vld;
    logic [AW-1:0]                  r_sq_idx;
    logic [SQ_W-1:0]                r_sq_r, r_sq_g, r_sq_b;

    logic [DIST_W-1:0]              r_best_dist;
    logic [AW-1:0]                  r_best_idx;

    logic                           r_out_valid;
    logic [npcs_pkg::INDEX_W-1:0]   r_out_index;

    logic                           w_in_fire;
    logic                           w_wr_en;
    logic                           w_query;
    logic                           w_more;
    logic                           w_drained;
    logic [CLR_W-1:0]               w_dr, w_dg, w_db;
    logic [DIST_W-1:0]              w_dist;

    assign o_cfg_ready     = 1'b1;
    assign o_in_ready      = w_ctrl.in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_index;

    assign w_in_fire = i_in_valid && w_ctrl.in_ready;
    assign w_wr_en   = w_in_fire && (i_op == npcs_pkg::OP_WRITE)
                       && ({1'b0, i_entry_index} < (npcs_pkg::INDEX_W + 1)'(PALETTE_DEPTH));
    assign w_query   = w_in_fire && (i_op == npcs_pkg::OP_QUERY);
    assign w_more    = (r_addr < r_count);
    assign w_drained = !w_more && !r_rd_vld && !r_sq_vld;

    assign n_count = (r_palette_count > npcs_pkg::COUNT_W'(PALETTE_DEPTH))
                     ? CW'(PALETTE_DEPTH) : CW'(r_palette_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            npcs_pkg::ST_IDLE: begin
                if (w_query) begin
                    n_state = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN: begin
                if (w_drained) begin
                    n_state = npcs_pkg::ST_DONE;
                end
            end
            npcs_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = npcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            npcs_pkg::ST_IDLE: begin
                w_ctrl.in_ready = 1'b1;
            end
            npcs_pkg::ST_SCAN: begin
                w_ctrl.issue = w_more;
            end
            npcs_pkg::ST_DONE: begin
                w_ctrl.load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= npcs_pkg::ST_IDLE;
            r_palette_count <= npcs_pkg::COUNT_RESET;
            r_rd_vld        <= 1'b0;
            r_sq_vld        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_addr          <= '0;
            r_count         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_palette_count <= i_cfg_data;
            end
            if (w_query) begin
                r_addr  <= '0;
                r_count <= n_count;
            end else if (w_ctrl.issue) begin
                r_addr <= r_addr + CW'(1);
            end
            r_rd_vld <= w_ctrl.issue;
            r_sq_vld <= r_rd_vld;
            if (w_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // palette memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_palette[i_entry_index[AW-1:0]] <= {i_red, i_green, i_blue};
        end
        if (w_ctrl.issue) begin
            r_rd_data <= r_palette[r_addr[AW-1:0]];
            r_rd_idx  <= r_addr[AW-1:0];
        end
    end

    // distance unit: channel squares, then sum and compare
    assign w_dr = (r_rd_data[3*CLR_W-1:2*CLR_W] > r_red)
                  ? r_rd_data[3*CLR_W-1:2*CLR_W] - r_red
                  : r_red - r_rd_data[3*CLR_W-1:2*CLR_W];
    assign w_dg = (r_rd_data[2*CLR_W-1:CLR_W] > r_green)
                  ? r_rd_data[2*CLR_W-1:CLR_W] - r_green
                  : r_green - r_rd_data[2*CLR_W-1:CLR_W];
    assign w_db = (r_rd_data[CLR_W-1:0] > r_blue)
                  ? r_rd_data[CLR_W-1:0] - r_blue
                  : r_blue - r_rd_data[CLR_W-1:0];

    assign w_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_red       <= i_red;
            r_green     <= i_green;
            r_blue      <= i_blue;
            r_best_dist <= npcs_pkg::DIST_START;
            r_best_idx  <= '0;
        end else if (r_sq_vld && (w_dist < r_best_dist)) begin
            r_best_dist <= w_dist;
            r_best_idx  <= r_sq_idx;
        end
        if (r_rd_vld) begin
            r_sq_r   <= SQ_W'(w_dr) * SQ_W'(w_dr);
            r_sq_g   <= SQ_W'(w_dg) * SQ_W'(w_dg);
            r_sq_b   <= SQ_W'(w_db) * SQ_W'(w_db);
            r_sq_idx <= r_rd_idx;
        end
        if (w_ctrl.load_out) begin
            r_out_index <= npcs_pkg::INDEX_W'(r_best_idx);
        end
    end

endmodule

>>> tb/sv/nearest_palette_color_search_top_test.sv
// self-checking testbench for the nearest palette color search top level
`timescale 1ns / 1ps

module nearest_palette_color_search_top_test;

    localparam int DEPTH       = npcs_pkg::DEFAULT_PALETTE_DEPTH;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int RGB_W       = 3 * npcs_pkg::COLOR_W;

    typedef struct {
        logic [npcs_pkg::INDEX_W-1:0] index;
        logic [RGB_W-1:0]             color;
    } t_query_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [npcs_pkg::COUNT_W-1:0]     i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic                             i_op;
    logic [npcs_pkg::INDEX_W-1:0]     i_entry_index;
    logic [npcs_pkg::COLOR_W-1:0]     i_red;
    logic [npcs_pkg::COLOR_W-1:0]     i_green;
    logic [npcs_pkg::COLOR_W-1:0]     i_blue;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [npcs_pkg::INDEX_W-1:0]     o_nearest_index;

    logic [RGB_W-1:0]                 palette_model [DEPTH];
    bit                               entry_written [DEPTH];
    int                               written_prefix = 0;
    logic [npcs_pkg::COUNT_W-1:0]     count_model = npcs_pkg::COUNT_RESET;
    bit                               steady = 1'b0;
    int                               failures = 0;
    int                               cycles = 0;
    t_query_result                    expected_results [$];

    nearest_palette_color_search_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_entry_index   (i_entry_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_nearest_index (o_nearest_index)
    );

    always #10 i_clk = ~i_clk;

    function automatic int scan_length();
        return (count_model > DEPTH) ? DEPTH : int'(count_model);
    endfunction

    function automatic logic [npcs_pkg::INDEX_W-1:0] nearest_entry(
        input logic [RGB_W-1:0] color
    );
        int best_dist;
        int distance;
        int dr;
        int dg;
        int db;
        logic [npcs_pkg::INDEX_W-1:0] best;
        best_dist = int'(npcs_pkg::DIST_START);
        best      = '0;
        for (int i = 0; i < scan_length(); i++) begin
            dr       = int'(palette_model[i][23:16]) - int'(color[23:16]);
            dg       = int'(palette_model[i][15:8]) - int'(color[15:8]);
            db       = int'(palette_model[i][7:0]) - int'(color[7:0]);
            distance = dr * dr + dg * dg + db * db;
            if (distance < best_dist) begin
                best_dist = distance;
                best      = npcs_pkg::INDEX_W'(i);
            end
        end
        return best;
    endfunction

    function automatic logic [RGB_W-1:0] pick_color();
        logic [RGB_W-1:0] c;
        int span;
        span = (scan_length() < written_prefix) ? scan_length() : written_prefix;
        case ($urandom_range(0, 9))
            0, 1: begin
                c = {(($urandom_range(0, 1) != 0) ? 8'hff : 8'h00),
                     (($urandom_range(0, 1) != 0) ? 8'hff : 8'h00),
                     (($urandom_range(0, 1) != 0) ? 8'hff : 8'h00)};
            end
            2, 3, 4: begin
                if (span > 0) begin
                    c = palette_model[$urandom_range(0, span - 1)];
                    if ($urandom_range(0, 1) != 0) begin
                        c = c ^ (RGB_W'($urandom) & 24'h030303);
                    end
                end else begin
                    c = RGB_W'($urandom);
                end
            end
            default: begin
                c = RGB_W'($urandom);
            end
        endcase
        return c;
    endfunction

    task automatic send_request(input logic op, input logic [npcs_pkg::INDEX_W-1:0] idx,
                                input logic [RGB_W-1:0] color);
        t_query_result pending;
        while (!steady && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_red         <= color[23:16];
        i_green       <= color[15:8];
        i_blue        <= color[7:0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == npcs_pkg::OP_WRITE) begin
            palette_model[idx] = color;
            entry_written[idx] = 1'b1;
            while (written_prefix < DEPTH && entry_written[written_prefix]) written_prefix++;
        end else begin
            pending.index = nearest_entry(color);
            pending.color = color;
            expected_results.insert(expected_results.size(), pending);
        end
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (scan_length() + 8) @(posedge i_clk);
    endtask

    task automatic write_palette_count(input logic [npcs_pkg::COUNT_W-1:0] value);
        wait_until_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        count_model = value;
    endtask

    task automatic test_empty_palette();
        write_palette_count(npcs_pkg::COUNT_W'(0));
        send_request(npcs_pkg::OP_QUERY, 8'hff, 24'h000000);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'hffffff);
        send_request(npcs_pkg::OP_WRITE, 8'hff, 24'hffffff);
        send_request(npcs_pkg::OP_QUERY, 8'h55, 24'h808080);
    endtask

    task automatic test_extreme_colors();
        write_palette_count(npcs_pkg::COUNT_W'(2));
        send_request(npcs_pkg::OP_WRITE, 8'h00, 24'h000000);
        send_request(npcs_pkg::OP_WRITE, 8'h01, 24'hffffff);
        send_request(npcs_pkg::OP_QUERY, 8'haa, 24'h000000);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'hffffff);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h808080);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h7f7f7f);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'hff0000);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h00ffff);
    endtask

    task automatic test_tie_break();
        write_palette_count(npcs_pkg::COUNT_W'(4));
        send_request(npcs_pkg::OP_WRITE, 8'h02, 24'h000000);
        send_request(npcs_pkg::OP_WRITE, 8'h03, 24'h5a5a5a);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h000000);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h5a5a5a);
        send_request(npcs_pkg::OP_WRITE, 8'h01, 24'h5a5a5a);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h5a5a5a);
        send_request(npcs_pkg::OP_QUERY, 8'h00, 24'h2d2d2d);
    endtask

    task automatic test_single_entry();
        write_palette_count(npcs_pkg::COUNT_W'(1));
        send_request(npcs_pkg::OP_QUERY, 8'h0f, 24'hffffff);
    endtask

    task automatic test_random_search(input logic [npcs_pkg::COUNT_W-1:0] count,
                                      input int items, input bit no_idle);
        logic [npcs_pkg::INDEX_W-1:0] idx;
        int n;
        write_palette_count(count);
        steady = no_idle;
        for (int k = 0; k < items; k++) begin
            n = scan_length();
            if ($urandom_range(0, 99) < 55 && written_prefix >= n) begin
                send_request(npcs_pkg::OP_QUERY, npcs_pkg::INDEX_W'($urandom), pick_color());
            end else begin
                if (written_prefix < n && $urandom_range(0, 3) != 0) begin
                    idx = npcs_pkg::INDEX_W'(written_prefix);
                end else if (n > 0 && $urandom_range(0, 3) != 0) begin
                    idx = npcs_pkg::INDEX_W'($urandom_range(0, n - 1));
                end else begin
                    idx = npcs_pkg::INDEX_W'($urandom);
                end
                send_request(npcs_pkg::OP_WRITE, idx, pick_color());
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_query_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("unexpected result: nearest_index %0d", o_nearest_index);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_nearest_index !== want.index) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("query %06h: nearest_index expected %0d, got %0d",
                                 want.color, want.index, o_nearest_index);
                    end
                end
            end
        end
        i_out_ready <= steady || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_op          <= npcs_pkg::OP_WRITE;
        i_entry_index <= '0;
        i_red         <= '0;
        i_green       <= '0;
        i_blue        <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            palette_model[i] = '0;
            entry_written[i] = 1'b0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_palette();
        test_extreme_colors();
        test_tie_break();
        test_single_entry();
        test_random_search(npcs_pkg::COUNT_W'($urandom_range(2, 16)), 150, 1'b0);
        test_random_search(npcs_pkg::COUNT_W'(256), 500, 1'b0);
        test_random_search(npcs_pkg::COUNT_W'(511), 120, 1'b0);
        test_random_search(npcs_pkg::COUNT_W'(255), 80, 1'b0);
        test_random_search(npcs_pkg::COUNT_W'(1), 60, 1'b0);
        test_random_search(npcs_pkg::COUNT_W'($urandom_range(17, 64)), 120, 1'b1);

        wait_until_idle();
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
